### sv/motor_feedback_frame_tracker_top_macros.svh
`ifndef MOTOR_FEEDBACK_FRAME_TRACKER_TOP_MACROS_SVH
`define MOTOR_FEEDBACK_FRAME_TRACKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MFFT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MFFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mfft_pkg.sv
`default_nettype none

package mfft_pkg;

	localparam logic [10:0] FIRST_BASE  = 11'h200;
	localparam logic [10:0] SECOND_BASE = 11'h204;
	localparam logic [10:0] SECOND_LOW  = 11'h205;
	localparam logic [10:0] SECOND_HIGH = 11'h20B;
	localparam logic [3:0]  FRAME_LEN   = 4'd8;

	localparam logic signed [17:0] HALF_TURN = 18'sd4096;
	localparam logic signed [17:0] FULL_TURN = 18'sd8192;

	localparam logic [10:0] FIRST_ID_RESET = 11'd513;
	localparam logic [10:0] LAST_ID_RESET  = 11'd523;

	typedef enum logic [2:0] {
		REG_ON_SECOND_BUS     = 3'd0,
		REG_FIRST_FEEDBACK_ID = 3'd1,
		REG_LAST_FEEDBACK_ID  = 3'd2,
		REG_REGISTERED_MASK   = 3'd3,
		REG_TEMPERATURE_MASK  = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic        on_second_bus;
		logic [10:0] first_feedback_id;
		logic [10:0] last_feedback_id;
		logic [10:0] registered_mask;
		logic [10:0] temperature_mask;
	} cfg_t;

	typedef struct packed {
		logic [10:0] frame_id;
		logic        extended_id;
		logic        remote_request;
		logic [3:0]  data_length;
		logic [63:0] payload;
		logic [31:0] time_stamp;
	} frame_t;

	typedef struct packed {
		logic               updated;
		logic [3:0]         motor_number;
		logic [15:0]        angle;
		logic signed [15:0] rotor_speed;
		logic signed [15:0] phase_current;
		logic [7:0]         temperature;
		logic signed [31:0] total_count;
		logic [31:0]        sample_count;
		logic [31:0]        stamp;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] motor;
		logic       report_temp;
	} check_t;

endpackage

`default_nettype wire

### sv/motor_feedback_frame_tracker_top.sv
// channel | direction | handshake              | payload
// in      | in        | in_valid / in_ready    | in_item   (frame_t)
// out     | out       | out_valid / out_ready  | out_item  (result_t)
// cfg     | in        | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One frame per cycle unless the result stalls.
// Frame check and per-motor read-modify-write sit between the input register
// and the result register; state is written on the same edge as the result.
// Reset clears config to defaults and all per-motor state to zero at once.
// A stalled result holds the input register; a new frame is taken whenever
// the input register is empty or moves on in the same cycle.
`default_nettype none

`include "motor_feedback_frame_tracker_top_macros.svh"

module motor_feedback_frame_tracker_top import mfft_pkg::*; #(
	parameter int MOTOR_COUNT = 11
) (
	input  var logic    clk,
	input  var logic    arst_n,
	input  var logic    in_valid,
	output logic        in_ready,
	input  var frame_t  in_item,
	output logic        out_valid,
	input  var logic    out_ready,
	output result_t     out_item,
	input  var logic    cfg_we,
	input  var logic [2:0]  cfg_index,
	input  var logic [10:0] cfg_wdata
);

	localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	cfg_t    cfg_q;
	logic    valid_s1;
	frame_t  item_s1;
	logic    out_valid_q;
	result_t out_q;
	check_t  check;
	logic    advance;
	logic    hit;

	logic [15:0] prev_angle_q  [MOTOR_COUNT];
	logic [31:0] turn_total_q  [MOTOR_COUNT];
	logic [31:0] frames_seen_q [MOTOR_COUNT];
	logic [31:0] last_stamp_q  [MOTOR_COUNT];

	logic [IDX_W-1:0]   idx;
	logic [15:0]        angle;
	logic [15:0]        prev;
	logic [31:0]        frames;
	logic signed [17:0] diff;
	logic signed [17:0] step;
	logic [31:0]        new_total;
	logic [31:0]        new_frames;
	result_t            res;

	mfft_filter #(.MOTOR_COUNT(MOTOR_COUNT)) u_filter (
		.cfg   (cfg_q),
		.frame (item_s1),
		.check (check)
	);

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign hit       = advance && check.ok;

	always_comb begin
		idx    = IDX_W'(check.motor - 4'd1);
		angle  = item_s1.payload[63:48];
		prev   = prev_angle_q[idx];
		frames = frames_seen_q[idx];
		diff   = $signed({2'b00, angle}) - $signed({2'b00, prev});
		priority if (diff > HALF_TURN) begin
			step = diff - FULL_TURN;
		end else if (diff < -HALF_TURN) begin
			step = diff + FULL_TURN;
		end else begin
			step = diff;
		end
		new_total  = (frames == 32'd0) ? 32'd0 :
			turn_total_q[idx] + 32'($signed(step));
		new_frames = frames + 32'd1;

		res = '0;
		if (check.ok) begin
			res.updated       = 1'b1;
			res.motor_number  = check.motor;
			res.angle         = angle;
			res.rotor_speed   = item_s1.payload[47:32];
			res.phase_current = item_s1.payload[31:16];
			res.temperature   = check.report_temp ? item_s1.payload[15:8] : 8'd0;
			res.total_count   = new_total;
			res.sample_count  = new_frames;
			res.stamp         = item_s1.time_stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_second_bus     <= 1'b0;
			cfg_q.first_feedback_id <= FIRST_ID_RESET;
			cfg_q.last_feedback_id  <= LAST_ID_RESET;
			cfg_q.registered_mask   <= '0;
			cfg_q.temperature_mask  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ON_SECOND_BUS:     cfg_q.on_second_bus     <= cfg_wdata[0];
				REG_FIRST_FEEDBACK_ID: cfg_q.first_feedback_id <= cfg_wdata;
				REG_LAST_FEEDBACK_ID:  cfg_q.last_feedback_id  <= cfg_wdata;
				REG_REGISTERED_MASK:   cfg_q.registered_mask   <= cfg_wdata;
				REG_TEMPERATURE_MASK:  cfg_q.temperature_mask  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				prev_angle_q[i]  <= '0;
				turn_total_q[i]  <= '0;
				frames_seen_q[i] <= '0;
				last_stamp_q[i]  <= '0;
			end
		end else if (hit) begin
			prev_angle_q[idx]  <= angle;
			turn_total_q[idx]  <= new_total;
			frames_seen_q[idx] <= new_frames;
			last_stamp_q[idx]  <= item_s1.time_stamp;
		end
	end

	`MFFT_ASSERT_NOW(a_reject_clean, out_valid && !out_item.updated, (out_item.motor_number == 4'd0) && (out_item.sample_count == 32'd0), "rejected result carries data")
	`MFFT_ASSERT_NOW(a_motor_range, out_valid && out_item.updated, (out_item.motor_number != 4'd0) && (out_item.motor_number <= 4'(MOTOR_COUNT)), "motor number out of range")
	`MFFT_ASSERT_NEXT(a_count_step, hit, frames_seen_q[$past(idx)] == $past(frames) + 32'd1, "frame count did not advance")
	`MFFT_ASSERT_NEXT(a_result_follows, advance, out_valid, "result lost after advance")

endmodule

`default_nettype wire

### sv/mfft_filter.sv
`default_nettype none

module mfft_filter import mfft_pkg::*; #(
	parameter int MOTOR_COUNT = 11
) (
	input  var cfg_t   cfg,
	input  var frame_t frame,
	output check_t     check
);

	logic [10:0] first_off;
	logic [10:0] second_off;
	logic        form_ok;
	logic        first_win;
	logic        second_win;
	logic        win_ok;
	logic [3:0]  motor;
	logic [3:0]  bit_sel;
	logic [10:0] reg_sh;
	logic [10:0] temp_sh;

	always_comb begin
		first_off  = frame.frame_id - FIRST_BASE;
		second_off = frame.frame_id - SECOND_BASE;
		form_ok = !frame.extended_id && !frame.remote_request &&
			(frame.data_length == FRAME_LEN);
		first_win = (frame.frame_id >= cfg.first_feedback_id) &&
			(frame.frame_id <= cfg.last_feedback_id) &&
			(frame.frame_id >= FIRST_BASE) &&
			(first_off >= 11'd1) && (first_off <= 11'(MOTOR_COUNT));
		second_win = (frame.frame_id >= SECOND_LOW) && (frame.frame_id <= SECOND_HIGH) &&
			(second_off <= 11'(MOTOR_COUNT));
		win_ok  = cfg.on_second_bus ? second_win : first_win;
		motor   = cfg.on_second_bus ? second_off[3:0] : first_off[3:0];
		bit_sel = motor - 4'd1;
		reg_sh  = cfg.registered_mask >> bit_sel;
		temp_sh = cfg.temperature_mask >> bit_sel;

		check.ok          = form_ok && win_ok && reg_sh[0];
		check.motor       = motor;
		check.report_temp = temp_sh[0];
	end

endmodule

`default_nettype wire
